// File: design/lrib_pkg.sv
// Package for the lidar range image binner: codes, register indexes and
// fixed constants of the column division. Used by the top level; no dependencies.
`default_nettype none

package lrib_pkg;

  // Fixed image height and the azimuth range of one turn, in hundredths of a degree.
  localparam int unsigned LRIB_ROWS      = 64;
  localparam int unsigned LRIB_AZ_LIMIT  = 36000;

  // Reciprocal of the azimuth range, scaled by two to the power of the shift.
  localparam int unsigned     LRIB_RECIP_SHIFT = 32;
  localparam longint unsigned LRIB_RECIP = (64'd1 << LRIB_RECIP_SHIFT) / 64'd36000;

  // Default sizes of the pixel store.
  localparam int unsigned LRIB_MAX_COLUMNS_DEF = 512;
  localparam int unsigned LRIB_MAX_SLOTS_DEF   = 8;
  localparam int unsigned LRIB_POINT_BITS_DEF  = 16;

  // Item kinds.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] STATUS_STORED   = 3'd0;
  localparam logic [2:0] STATUS_AZ_RANGE = 3'd1;
  localparam logic [2:0] STATUS_FULL     = 3'd2;
  localparam logic [2:0] STATUS_POINT    = 3'd3;
  localparam logic [2:0] STATUS_EMPTY    = 3'd4;
  localparam logic [2:0] STATUS_CLEARED  = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_RES      = 3'd0;
  localparam logic [2:0] REG_MAX_POINTS = 3'd1;
  localparam logic [2:0] REG_ROW_MAP_0  = 3'd2;

  // One result item as held before it is offered on the output.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] point;
    logic [3:0]  count;
    logic        last;
  } lrib_res_t;

endpackage

`default_nettype wire

// File: design/lidar_range_image_binner_unit.sv
// Lidar range image binner: sorts points into a 64-row range image whose pixels each
// keep a short list of point numbers, and answers queries and clears. An add goes
// through a chain of three registered multiplications that turns the azimuth into
// a column, then a read-modify-write of the pixel count memory. A query reads the
// pixel count, then makes one slot memory read for every stored point. A clear, and
// the clearing pass after reset, sweep all 64*MAX_COLUMNS pixels (32768 by default)
// of the count memory one pixel a cycle, during which no item is taken. The result
// sits in an output register, so the next item is taken while it waits. Depends on
// lrib_pkg, lrib_ram.
`default_nettype none

module lidar_range_image_binner_unit
  import lrib_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = LRIB_MAX_COLUMNS_DEF,
  parameter int unsigned MAX_SLOTS   = LRIB_MAX_SLOTS_DEF,
  parameter int unsigned POINT_BITS  = LRIB_POINT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // Input items.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] azimuth,
  input  wire logic [5:0]  laser_id,
  input  wire logic [15:0] point_number,
  input  wire logic [8:0]  query_column,
  input  wire logic [5:0]  query_row,
  // Result items.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      stored_point,
  output logic [3:0]       pixel_count,
  output logic             last
);

  localparam int unsigned NPIX    = LRIB_ROWS * MAX_COLUMNS;
  localparam int unsigned PIX_AW  = $clog2(NPIX);
  localparam int unsigned NSLOT   = NPIX * MAX_SLOTS;
  localparam int unsigned SLOT_AW = $clog2(NSLOT);
  localparam int unsigned CW      = $clog2(MAX_SLOTS + 1);

  // Widths of the column division, fixed by the azimuth and x_res fields.
  localparam int unsigned P_W  = 26;
  localparam int unsigned PK_W = 43;
  localparam int unsigned Q_W  = 11;
  localparam int unsigned QM_W = 27;

  localparam logic [PIX_AW-1:0]  MC_PIX   = PIX_AW'(MAX_COLUMNS);
  localparam logic [SLOT_AW-1:0] MS_SLOT  = SLOT_AW'(MAX_SLOTS);
  localparam logic [PIX_AW-1:0]  PIX_LAST = PIX_AW'(NPIX - 1);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_QUO   = 4'd3;
  localparam logic [3:0] ST_COL   = 4'd4;
  localparam logic [3:0] ST_ADR   = 4'd5;
  localparam logic [3:0] ST_RD    = 4'd6;
  localparam logic [3:0] ST_CHK   = 4'd7;
  localparam logic [3:0] ST_SRD   = 4'd8;
  localparam logic [3:0] ST_SOUT  = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  // Configuration registers.
  logic [9:0]  x_res;
  logic [3:0]  max_points;
  logic [63:0] row_map [6];
  logic [383:0] map_bits;

  // Control state.
  logic [3:0]        state;
  logic              clr_item;
  logic [PIX_AW-1:0] clr_addr;

  // Latched item and working registers.
  logic [1:0]         kind_r;
  logic [5:0]         laser_r;
  logic [15:0]        point_r;
  logic [8:0]         qcol_r;
  logic [5:0]         qrow_r;
  logic [P_W-1:0]     prod_p;
  logic [PK_W-1:0]    prod_k;
  logic [Q_W-1:0]     quo;
  logic [QM_W-1:0]    quo_m;
  logic [Q_W-1:0]     col;
  logic [PIX_AW-1:0]  pix;
  logic [SLOT_AW-1:0] slot_base;
  logic [CW-1:0]      qcnt;
  logic [CW-1:0]      k;
  lrib_res_t          res;

  // Combinational helpers.
  logic               in_xfer;
  logic               out_load;
  logic [QM_W-1:0]    rem;
  logic [5:0]         map_row;
  logic [Q_W-1:0]     adr_col;
  logic [5:0]         adr_row;
  logic               adr_oor;
  logic               full;
  logic [31:0]        pt_ext;

  // Memory ports.
  logic               cnt_we;
  logic [PIX_AW-1:0]  cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic               cnt_re;
  logic [CW-1:0]      cnt_rdata;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic               slot_re;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [POINT_BITS-1:0] slot_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_res      <= 10'd512;
      max_points <= 4'd8;
      for (int i = 0; i < 6; i++) begin
        row_map[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_X_RES) begin
        x_res <= cfg_data[9:0];
      end else if (cfg_index == REG_MAX_POINTS) begin
        max_points <= cfg_data[3:0];
      end else begin
        row_map[3'(cfg_index - REG_ROW_MAP_0)] <= cfg_data;
      end
    end
  end

  // Laser id to row, six bits per id.
  assign map_bits = {row_map[5], row_map[4], row_map[3], row_map[2], row_map[1], row_map[0]};
  assign map_row  = map_bits[{3'b000, laser_r} * 9'd6 +: 6];

  // Remainder check that corrects the reciprocal quotient by at most one.
  assign rem = {1'b0, prod_p} - quo_m;

  // Pixel addressing, shared by adds and queries.
  assign adr_col = (kind_r == KIND_ADD) ? col : {2'b00, qcol_r};
  assign adr_row = (kind_r == KIND_ADD) ? map_row : qrow_r;
  assign adr_oor = (adr_col >= {1'b0, x_res}) || (32'(adr_col) >= 32'(MAX_COLUMNS));

  // A pixel is full at the configured limit or at the slot capacity.
  assign full = (32'(cnt_rdata) >= 32'(max_points)) || (32'(cnt_rdata) >= 32'(MAX_SLOTS));

  assign pt_ext = {16'h0000, point_r};

  // Memory port control: sweep or read-modify-write of the count, slot fill and read.
  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = pix;
    cnt_wdata  = CW'(cnt_rdata + 1'b1);
    slot_we    = 1'b0;
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else if ((state == ST_CHK) && (kind_r == KIND_ADD) && !full) begin
      cnt_we  = 1'b1;
      slot_we = 1'b1;
    end
  end

  assign cnt_re     = (state == ST_RD);
  assign slot_re    = (state == ST_SRD);
  assign slot_waddr = slot_base + SLOT_AW'(cnt_rdata);
  assign slot_raddr = slot_base + SLOT_AW'(k);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_item <= 1'b0;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PIX_LAST) begin
            if (clr_item) begin
              res   <= '{status: STATUS_CLEARED, point: 16'h0000, count: 4'h0, last: 1'b1};
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            kind_r  <= kind;
            laser_r <= laser_id;
            point_r <= point_number;
            qcol_r  <= query_column;
            qrow_r  <= query_row;
            prod_p  <= {10'h000, azimuth} * {16'h0000, x_res};
            case (kind)
              KIND_ADD:   state <= ST_MUL;
              KIND_QUERY: state <= ST_ADR;
              KIND_CLEAR: begin
                clr_item <= 1'b1;
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              default:    state <= ST_IDLE;
            endcase
          end
        end
        ST_MUL: begin
          prod_k <= {17'h00000, prod_p} * PK_W'(LRIB_RECIP);
          state  <= ST_QUO;
        end
        ST_QUO: begin
          quo   <= prod_k[PK_W-1 -: Q_W];
          quo_m <= {16'h0000, prod_k[PK_W-1 -: Q_W]} * QM_W'(LRIB_AZ_LIMIT);
          state <= ST_COL;
        end
        ST_COL: begin
          col   <= quo + Q_W'(rem >= QM_W'(LRIB_AZ_LIMIT));
          state <= ST_ADR;
        end
        ST_ADR: begin
          pix <= PIX_AW'(adr_row) * MC_PIX + PIX_AW'(adr_col);
          if (adr_oor) begin
            res.status <= (kind_r == KIND_ADD) ? STATUS_AZ_RANGE : STATUS_EMPTY;
            res.point  <= 16'h0000;
            res.count  <= 4'h0;
            res.last   <= 1'b1;
            state      <= ST_EMIT;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          slot_base <= SLOT_AW'(pix) * MS_SLOT;
          state     <= ST_CHK;
        end
        ST_CHK: begin
          res.point <= 16'h0000;
          res.last  <= 1'b1;
          if (kind_r == KIND_ADD) begin
            res.status <= full ? STATUS_FULL : STATUS_STORED;
            res.count  <= full ? 4'(cnt_rdata) : 4'(cnt_rdata + 1'b1);
            state      <= ST_EMIT;
          end else if (cnt_rdata == '0) begin
            res.status <= STATUS_EMPTY;
            res.count  <= 4'h0;
            state      <= ST_EMIT;
          end else begin
            qcnt  <= cnt_rdata;
            k     <= '0;
            state <= ST_SRD;
          end
        end
        ST_SRD: begin
          state <= ST_SOUT;
        end
        ST_SOUT: begin
          res.status <= STATUS_POINT;
          res.point  <= 16'(32'(slot_rdata));
          res.count  <= 4'(qcnt);
          res.last   <= (CW'(k + 1'b1) == qcnt);
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            if (res.last) begin
              clr_item <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_SRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register; the result waits here until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res.status;
      stored_point <= res.point;
      pixel_count  <= res.count;
      last         <= res.last;
    end
  end

  // Pixel count memory.
  lrib_ram #(
    .WIDTH (CW),
    .DEPTH (NPIX)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (pix),
    .rdata (cnt_rdata)
  );

  // Point slot memory, MAX_SLOTS entries per pixel.
  lrib_ram #(
    .WIDTH (POINT_BITS),
    .DEPTH (NSLOT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (pt_ext[POINT_BITS-1:0]),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // A new result appears only from the emit state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result offered outside the emit state");

  // Every reset is followed by the clearing pass over the count memory.
  assert property (@(posedge clk) $past(rst) && !rst |-> state == ST_CLEAR)
    else $error("clearing pass did not start after reset");

  // A pixel count never grows beyond the slot capacity.
  assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> 32'(cnt_wdata) <= 32'(MAX_SLOTS))
    else $error("pixel count written beyond slot capacity");

  // A slot is written only below the pixel's capacity, together with its count.
  assert property (@(posedge clk) disable iff (rst)
    slot_we |-> cnt_we && (32'(cnt_rdata) < 32'(MAX_SLOTS)))
    else $error("slot write outside the pixel's capacity");

endmodule

`default_nettype wire

// File: design/lrib_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module lrib_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read; read data holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
